@@ src/h264fua_pkg.sv @@
`default_nettype none

package h264fua_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SSRC_ID      = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

    localparam logic [31:0] SSRC_RESET = 32'd0;
    localparam logic [6:0]  PT_RESET   = 7'd96;
    localparam logic [10:0] MAXP_RESET = 11'd1024;

    // RTP and FU-A header constants.
    localparam logic [7:0] RTP_V2    = 8'h80;
    localparam logic [7:0] FU_A_TYPE = 8'd28;
    localparam logic [7:0] NRI_MASK  = 8'hE0;
    localparam logic [7:0] TYPE_MASK = 8'h1F;
    localparam logic [7:0] FU_S_BIT  = 8'h80;
    localparam logic [7:0] FU_E_BIT  = 8'h40;

    // Number of bytes in each kind of output burst.
    localparam logic [3:0] CNT_DATA_ONLY   = 4'd1;
    localparam logic [3:0] CNT_HEADER_ONLY = 4'd13;
    localparam logic [3:0] CNT_SINGLE      = 4'd14;
    localparam logic [3:0] CNT_FU_A        = 4'd15;

    localparam int JOB_BYTES = 15;

    // One burst of packet bytes, element 0 goes out first.
    typedef struct packed {
        logic                         load;
        logic [3:0]                   count;
        logic                         first;
        logic                         last;
        logic [JOB_BYTES-1:0][7:0]    bytes;
    } job_t;

    function automatic logic [11:0][7:0] rtp_header(
        input logic        marker,
        input logic [6:0]  pt,
        input logic [15:0] seq,
        input logic [31:0] ts,
        input logic [31:0] ssrc
    );
        logic [11:0][7:0] h;
        h[0]  = RTP_V2;
        h[1]  = {marker, pt};
        h[2]  = seq[15:8];
        h[3]  = seq[7:0];
        h[4]  = ts[31:24];
        h[5]  = ts[23:16];
        h[6]  = ts[15:8];
        h[7]  = ts[7:0];
        h[8]  = ssrc[31:24];
        h[9]  = ssrc[23:16];
        h[10] = ssrc[15:8];
        h[11] = ssrc[7:0];
        return h;
    endfunction

endpackage

`default_nettype wire

@@ src/h264fua_if.sv @@
`default_nettype none

interface h264fua_nal_if;
    logic        valid;
    logic        ready;
    logic [7:0]  nal_byte;
    logic        nal_start;
    logic [15:0] nal_length;
    logic [31:0] frame_time;

    modport source (output valid, nal_byte, nal_start, nal_length, frame_time, input ready);
    modport sink   (input valid, nal_byte, nal_start, nal_length, frame_time, output ready);
endinterface

interface h264fua_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       pkt_first;
    logic       pkt_last;

    modport source (output valid, pkt_byte, pkt_first, pkt_last, input ready);
    modport sink   (input valid, pkt_byte, pkt_first, pkt_last, output ready);
endinterface

interface h264fua_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/h264fua_ctl.sv @@
`default_nettype none

module h264fua_ctl
    import h264fua_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 1040
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  nal_byte,
    input  wire logic        nal_start,
    input  wire logic [15:0] nal_length,
    input  wire logic [31:0] frame_time,
    input  wire logic [31:0] ssrc_id,
    input  wire logic [6:0]  payload_type,
    input  wire logic [10:0] max_payload,
    output job_t             job
);

    localparam logic [10:0] LIM = 11'(MAX_PACKET_BYTES - 16);

    logic [15:0] seq_counter_reg, seq_counter_next;
    logic [7:0]  nal_header_reg, nal_header_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [10:0] chunk_fill_reg, chunk_fill_next;
    logic [31:0] held_time_reg, held_time_next;
    logic        first_fragment_reg, first_fragment_next;
    logic        single_mode_reg, single_mode_next;

    logic [10:0] mp;
    logic        last_chunk;
    logic        end_chunk;

    // Effective chunk size: clamp to one and to the packet limit.
    always_comb
    begin
        if (max_payload == 11'd0)
        begin
            mp = 11'd1;
        end
        else if (max_payload > LIM)
        begin
            mp = LIM;
        end
        else
        begin
            mp = max_payload;
        end
    end

    assign last_chunk = single_mode_reg || (bytes_left_reg <= {5'd0, mp});
    assign end_chunk  = (bytes_left_reg == 16'd1)
                     || (!single_mode_reg && (({1'b0, chunk_fill_reg} + 12'd1) >= {1'b0, mp}));

    always_comb
    begin
        seq_counter_next    = seq_counter_reg;
        nal_header_next     = nal_header_reg;
        bytes_left_next     = bytes_left_reg;
        chunk_fill_next     = chunk_fill_reg;
        held_time_next      = held_time_reg;
        first_fragment_next = first_fragment_reg;
        single_mode_next    = single_mode_reg;
        job                 = '0;

        if (accept)
        begin
            if (nal_start)
            begin
                nal_header_next     = nal_byte;
                held_time_next      = frame_time;
                chunk_fill_next     = 11'd0;
                first_fragment_next = 1'b1;
                if (nal_length <= 16'd1)
                begin
                    // A NAL made of its header alone goes out at once.
                    bytes_left_next     = 16'd0;
                    single_mode_next    = 1'b1;
                    first_fragment_next = 1'b0;
                    seq_counter_next    = seq_counter_reg + 16'd1;
                    job.load            = 1'b1;
                    job.count           = CNT_HEADER_ONLY;
                    job.first           = 1'b1;
                    job.last            = 1'b1;
                    job.bytes[11:0]     = rtp_header(1'b1, payload_type, seq_counter_reg,
                                                     frame_time, ssrc_id);
                    job.bytes[12]       = nal_byte;
                end
                else
                begin
                    bytes_left_next  = nal_length - 16'd1;
                    single_mode_next = (nal_length - 16'd1) <= {5'd0, mp};
                end
            end
            else if (bytes_left_reg != 16'd0)
            begin
                job.load        = 1'b1;
                job.last        = end_chunk;
                bytes_left_next = bytes_left_reg - 16'd1;
                chunk_fill_next = end_chunk ? 11'd0 : chunk_fill_reg + 11'd1;
                if (chunk_fill_reg == 11'd0)
                begin
                    seq_counter_next    = seq_counter_reg + 16'd1;
                    first_fragment_next = 1'b0;
                    job.first           = 1'b1;
                    job.bytes[11:0]     = rtp_header(last_chunk, payload_type, seq_counter_reg,
                                                     held_time_reg, ssrc_id);
                    if (single_mode_reg)
                    begin
                        job.count     = CNT_SINGLE;
                        job.bytes[12] = nal_header_reg;
                        job.bytes[13] = nal_byte;
                    end
                    else
                    begin
                        job.count     = CNT_FU_A;
                        job.bytes[12] = FU_A_TYPE | (nal_header_reg & NRI_MASK);
                        job.bytes[13] = (first_fragment_reg ? FU_S_BIT : 8'h00)
                                      | (last_chunk ? FU_E_BIT : 8'h00)
                                      | (nal_header_reg & TYPE_MASK);
                        job.bytes[14] = nal_byte;
                    end
                end
                else
                begin
                    job.count    = CNT_DATA_ONLY;
                    job.bytes[0] = nal_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_counter_reg    <= '0;
            nal_header_reg     <= '0;
            bytes_left_reg     <= '0;
            chunk_fill_reg     <= '0;
            held_time_reg      <= '0;
            first_fragment_reg <= 1'b1;
            single_mode_reg    <= 1'b0;
        end
        else
        begin
            seq_counter_reg    <= seq_counter_next;
            nal_header_reg     <= nal_header_next;
            bytes_left_reg     <= bytes_left_next;
            chunk_fill_reg     <= chunk_fill_next;
            held_time_reg      <= held_time_next;
            first_fragment_reg <= first_fragment_next;
            single_mode_reg    <= single_mode_next;
        end
    end

    // The sequence number moves only when a packet header is issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_counter_reg != $past(seq_counter_reg)) |-> $past(job.load && job.first))
        else $error("sequence number changed without a packet header");

    // A stray payload byte with nothing outstanding produces no output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !nal_start && bytes_left_reg == 16'd0) |-> !job.load)
        else $error("stray payload byte produced output");

endmodule

`default_nettype wire

@@ src/h264fua_emit.sv @@
`default_nettype none

module h264fua_emit
    import h264fua_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  job_t          job,
    output logic          free,
    h264fua_pkt_if.source pkt
);

    logic [JOB_BYTES-1:0][7:0] sh_reg, sh_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      first_reg, first_next;
    logic                      last_reg, last_next;
    logic                      pop;
    logic                      load;

    assign pop  = pkt.valid && pkt.ready;
    assign free = (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && pkt.ready);
    assign load = job.load && free;

    assign pkt.valid     = (cnt_reg != 4'd0);
    assign pkt.pkt_byte  = sh_reg[0];
    assign pkt.pkt_first = first_reg;
    assign pkt.pkt_last  = last_reg && (cnt_reg == 4'd1);

    always_comb
    begin
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (load)
        begin
            sh_next    = job.bytes;
            cnt_next   = job.count;
            first_next = job.first;
            last_next  = job.last;
        end
        else if (pop)
        begin
            sh_next    = {8'h00, sh_reg[JOB_BYTES-1:1]};
            cnt_next   = cnt_reg - 4'd1;
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    // A burst that opens a packet shows the RTP version byte next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && job.first) |=> (pkt.valid && pkt.pkt_first && pkt.pkt_byte == RTP_V2))
        else $error("packet did not open with the RTP version byte");

    // Once the closing byte leaves with nothing new loaded, the output goes quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pkt.pkt_last && !job.load) |=> !pkt.valid)
        else $error("output stayed valid after the last packet byte");

endmodule

`default_nettype wire

@@ src/h264_rtp_fua_packetizer.sv @@
// A NAL byte accepted at a clock edge shows its first output byte in the cycle after.
// Throughput: one NAL byte per cycle while the receiver is ready; a byte that opens a packet
// holds the input for its burst (13 to 15 bytes), set by the single output shift register.
// Reset (rst_n, asynchronous, active low) clears the sequence number and NAL state,
// empties the output register and returns the configuration to its reset values.
`default_nettype none

module h264_rtp_fua_packetizer
    import h264fua_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 1040
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    h264fua_nal_if.sink   nal,
    h264fua_pkt_if.source pkt,
    h264fua_cfg_if.sink   cfg
);

    // Configuration registers. The user must write them only while the block is idle; the block
    // itself does not enforce this, and the packet header logic reads them directly.
    logic [31:0] ssrc_id_reg;
    logic [6:0]  payload_type_reg;
    logic [10:0] max_payload_reg;

    job_t job;
    logic free;
    logic accept;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssrc_id_reg      <= SSRC_RESET;
            payload_type_reg <= PT_RESET;
            max_payload_reg  <= MAXP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SSRC_ID:      ssrc_id_reg      <= cfg.data;
                REG_PAYLOAD_TYPE: payload_type_reg <= cfg.data[6:0];
                REG_MAX_PAYLOAD:  max_payload_reg  <= cfg.data[10:0];
                default:          ;
            endcase
        end
    end

    // A new NAL byte is taken whenever the output register is empty or is
    // handing over its final byte in this cycle. Bytes that produce no output
    // (the NAL header byte, stray bytes) follow the same rule.
    assign nal.ready = free;
    assign accept    = nal.valid && free;

    // The control stage owns the per-NAL state and builds each output burst (RTP header,
    // then the NAL header or the FU indicator and FU header where needed, then the byte).
    h264fua_ctl #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .nal_byte     (nal.nal_byte),
        .nal_start    (nal.nal_start),
        .nal_length   (nal.nal_length),
        .frame_time   (nal.frame_time),
        .ssrc_id      (ssrc_id_reg),
        .payload_type (payload_type_reg),
        .max_payload  (max_payload_reg),
        .job          (job)
    );

    // The emitter registers the burst and shifts it out one byte per request.
    h264fua_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job),
        .free  (free),
        .pkt   (pkt)
    );

endmodule

`default_nettype wire

@@ sim/h264_rtp_fua_packetizer_tb.sv @@
module h264_rtp_fua_packetizer_tb
    import h264fua_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Largest packet the block is built for. The payload chunk can never exceed
    // this size less the header room, whatever max_payload says.
    localparam int          PKT_BYTES   = 1040;
    localparam int unsigned CHUNK_CEIL  = PKT_BYTES - 16;
    // Random requests per phase that the block actually consumes.
    localparam int          PHASE_ITEMS = 48;
    // Cycles allowed after the last expected byte before the sender goes on. The
    // block registers its answer to each request it takes, so SETTLE covers it.
    localparam int          SETTLE      = 4;
    localparam int          END_SETTLE  = 20;
    // Cycles in a row with no request taken on any channel before giving up.
    localparam int          WATCHDOG    = 2000;
    localparam int          MAX_REPORTS = 10;

    // One byte of an outgoing RTP packet, as seen on the packet channel.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } pkt_beat_t;

    // One request on the NAL channel.
    typedef struct packed {
        logic [7:0]  nbyte;
        logic        start;
        logic [15:0] len;
        logic [31:0] ts;
    } nal_req_t;

    typedef enum logic {ROW_NAL, ROW_CFG} row_kind_t;

    // One row of the directed stimulus. Rows with golden_on carry the whole
    // packet typed in by hand; all other rows are checked against the predictor.
    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   idx;
        logic [31:0]  data;
        nal_req_t     req;
        logic         golden_on;
        logic [103:0] golden;
    } dir_row_t;

    logic clk;
    logic rst_n;

    h264fua_nal_if nal_ch();
    h264fua_pkt_if pkt_ch();
    h264fua_cfg_if cfg_ch();

    h264_rtp_fua_packetizer #(
        .MAX_PACKET_BYTES(PKT_BYTES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .nal  (nal_ch),
        .pkt  (pkt_ch),
        .cfg  (cfg_ch)
    );

    // Packet bytes that the block still owes, oldest first.
    pkt_beat_t pending_bytes[$];

    // The testbench's own copy of the configuration registers.
    logic [31:0] reg_ssrc;
    logic [6:0]  reg_pt;
    logic [10:0] reg_maxp;

    // The testbench's own copy of the packetizer state.
    logic [15:0] seq_no;
    logic [7:0]  nal_hdr;
    logic [15:0] payload_left;
    logic [10:0] chunk_bytes;
    logic [31:0] pkt_ts;
    logic        open_first;
    logic        single_pkt;

    int send_idle_pct;
    int stall_pct;
    int items_sent;
    int fail_count;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Payload bytes allowed in one packet: max_payload clamped to 1 .. CHUNK_CEIL.
    function automatic int unsigned chunk_limit();
        int unsigned m;
        m = reg_maxp;
        if (m < 1) m = 1;
        if (m > CHUNK_CEIL) m = CHUNK_CEIL;
        return m;
    endfunction

    function automatic void emit(logic [7:0] b, logic f, logic l);
        pending_bytes.push_back('{data: b, first: f, last: l});
    endfunction

    // The 12-byte RTP header, all fields big-endian. Every header uses up one
    // sequence number, and the counter simply wraps at 16 bits.
    function automatic void emit_rtp_header(logic marker);
        emit(RTP_V2, 1'b1, 1'b0);
        emit({marker, reg_pt}, 1'b0, 1'b0);
        emit(seq_no[15:8], 1'b0, 1'b0);
        emit(seq_no[7:0], 1'b0, 1'b0);
        emit(pkt_ts[31:24], 1'b0, 1'b0);
        emit(pkt_ts[23:16], 1'b0, 1'b0);
        emit(pkt_ts[15:8], 1'b0, 1'b0);
        emit(pkt_ts[7:0], 1'b0, 1'b0);
        emit(reg_ssrc[31:24], 1'b0, 1'b0);
        emit(reg_ssrc[23:16], 1'b0, 1'b0);
        emit(reg_ssrc[15:8], 1'b0, 1'b0);
        emit(reg_ssrc[7:0], 1'b0, 1'b0);
        seq_no = seq_no + 16'd1;
    endfunction

    // Works out the packet bytes that one accepted NAL request causes and
    // appends them to pending_bytes. Flags a stray byte that the block ignores.
    task automatic packetize(input nal_req_t r, output bit ignored);
        int unsigned lim;
        logic        last_chunk;
        logic        end_chunk;
        lim = chunk_limit();
        ignored = 1'b0;
        if (r.start)
        begin
            // A header byte latches the NAL and drops whatever was still open.
            nal_hdr = r.nbyte;
            pkt_ts = r.ts;
            chunk_bytes = '0;
            open_first = 1'b1;
            if (r.len <= 16'd1)
            begin
                // Header-only NAL: a single packet goes out right away, marker set.
                payload_left = '0;
                single_pkt = 1'b1;
                emit_rtp_header(1'b1);
                emit(nal_hdr, 1'b0, 1'b1);
                open_first = 1'b0;
            end
            else
            begin
                payload_left = r.len - 16'd1;
                single_pkt = (payload_left <= lim);
            end
        end
        else if (payload_left == 16'd0)
        begin
            ignored = 1'b1;
        end
        else
        begin
            if (chunk_bytes == 11'd0)
            begin
                // This byte opens a packet. The marker and E bit use the limit
                // in force right now, even if it changes before the chunk ends.
                last_chunk = single_pkt || (payload_left <= lim);
                emit_rtp_header(last_chunk);
                if (single_pkt)
                begin
                    emit(nal_hdr, 1'b0, 1'b0);
                end
                else
                begin
                    emit(FU_A_TYPE | (nal_hdr & NRI_MASK), 1'b0, 1'b0);
                    emit((open_first ? FU_S_BIT : 8'h00) | (last_chunk ? FU_E_BIT : 8'h00) |
                         (nal_hdr & TYPE_MASK), 1'b0, 1'b0);
                end
                open_first = 1'b0;
            end
            // A fragment closes when it is full; the NAL's final byte always closes.
            // Since the last chunk is never empty, an exact multiple gets no
            // empty trailing packet.
            end_chunk = (payload_left == 16'd1) ||
                        (!single_pkt && (32'(chunk_bytes) + 1 >= lim));
            emit(r.nbyte, 1'b0, end_chunk);
            payload_left = payload_left - 16'd1;
            chunk_bytes = end_chunk ? 11'd0 : chunk_bytes + 11'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    // Sends one NAL request, with random idle cycles in front of it, and
    // predicts its result at the edge that takes it.
    task automatic push_nal(input logic [7:0] b, input logic s, input logic [15:0] len,
                            input logic [31:0] ts);
        nal_req_t req;
        bit       ignored;
        req = '{nbyte: b, start: s, len: len, ts: ts};
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            nal_ch.valid <= 1'b0;
            @(negedge clk);
        end
        nal_ch.valid      <= 1'b1;
        nal_ch.nal_byte   <= b;
        nal_ch.nal_start  <= s;
        nal_ch.nal_length <= len;
        nal_ch.frame_time <= ts;
        @(posedge clk);
        while (!nal_ch.ready)
            @(posedge clk);
        packetize(req, ignored);
        if (!ignored)
            items_sent++;
        @(negedge clk);
    endtask

    // Holds the sender back until every predicted byte has come out, then
    // lets the block settle, since a header byte shows nothing on the output.
    task automatic wait_for_packets();
        nal_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes one configuration register. The request is dropped afterwards
    // so that back-to-back writes never retime valid in one step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_SSRC_ID:      reg_ssrc = val;
            REG_PAYLOAD_TYPE: reg_pt   = val[6:0];
            REG_MAX_PAYLOAD:  reg_maxp = val[10:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Mostly well-formed NALs with random content, sized around the current
    // chunk limit so that single packets, fragments and exact multiples all
    // turn up. The rest is stray bytes and NALs cut short by the next header,
    // whose random lengths reach every bit of nal_length.
    task automatic send_random_nal();
        int unsigned lim;
        int unsigned roll;
        int unsigned len;
        int unsigned cap;
        int unsigned k;
        lim = chunk_limit();
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            repeat ($urandom_range(1, 3))
                push_nal(8'($urandom), 1'b0, 16'($urandom), $urandom);
        end
        else if (roll < 18)
        begin
            push_nal(8'($urandom), 1'b1, 16'($urandom), $urandom);
            repeat ($urandom_range(0, 5))
                push_nal(8'($urandom), 1'b0, 16'($urandom), $urandom);
        end
        else
        begin
            roll = $urandom_range(0, 9);
            cap = (3 * lim + 2 > 40) ? 40 : 3 * lim + 2;
            if (roll < 2)
                len = $urandom_range(0, 1);
            else if (roll < 4 && lim <= 12)
                len = 1 + lim * $urandom_range(1, 3);
            else
                len = $urandom_range(2, cap);
            push_nal(8'($urandom), 1'b1, 16'(len), $urandom);
            for (k = 1; k < len; k++)
                push_nal(8'($urandom), 1'b0, 16'($urandom), $urandom);
        end
    endtask

    // One phase: program all three registers while the block is idle, pick the
    // idle pattern, then stream random NALs. Junk above the payload type and
    // max_payload register widths must be dropped by the block.
    task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] ssrc,
                             input logic [6:0] pt, input logic [10:0] maxp);
        int start_count;
        int nals;
        wait_for_packets();
        write_reg(REG_SSRC_ID, ssrc);
        write_reg(REG_PAYLOAD_TYPE, {25'($urandom), pt});
        write_reg(REG_MAX_PAYLOAD, {21'($urandom), maxp});
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        start_count = items_sent;
        nals = 0;
        while (items_sent - start_count < PHASE_ITEMS)
        begin
            send_random_nal();
            nals++;
            // Now and then the sender stops until the output has caught up.
            if (nals == 10 || $urandom_range(0, 29) == 0)
                wait_for_packets();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic dir_row_t nal_row(logic [7:0] b, logic s, logic [15:0] len,
                                         logic [31:0] ts);
        dir_row_t r;
        r = '0;
        r.kind = ROW_NAL;
        r.req = '{nbyte: b, start: s, len: len, ts: ts};
        return r;
    endfunction

    // A header-only NAL whose 13-byte packet is given in full, first byte leftmost.
    function automatic dir_row_t golden_row(logic [7:0] b, logic [15:0] len, logic [31:0] ts,
                                            logic [103:0] pkt_bytes);
        dir_row_t r;
        r = nal_row(b, 1'b1, len, ts);
        r.golden_on = 1'b1;
        r.golden = pkt_bytes;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // The receiver stalls at random, changing ready only at falling edges.
    always @(negedge clk)
        pkt_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    task automatic report_mismatch(input string what, input pkt_beat_t want,
                                   input pkt_beat_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s: expected byte %02h first %0b last %0b, got byte %02h first %0b last %0b",
                     $time, what, want.data, want.first, want.last, got.data, got.first, got.last);
    endtask

    // Each packet byte taken is compared with the oldest prediction.
    always @(posedge clk)
    begin : pkt_check
        pkt_beat_t got;
        pkt_beat_t want;
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            got = '{data: pkt_ch.pkt_byte, first: pkt_ch.pkt_first, last: pkt_ch.pkt_last};
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("packet byte with nothing expected", '0, got);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got.data !== want.data || got.first !== want.first ||
                    got.last !== want.last)
                    report_mismatch("packet byte mismatch", want, got);
            end
        end
    end

    // Ends the run if no channel takes a request for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (nal_ch.valid && nal_ch.ready) || (pkt_ch.valid && pkt_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("h264_rtp_fua_packetizer_tb: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        dir_row_t directed[$];
        int       k;

        // Every input and the model state start from known values.
        rst_n = 1'b0;
        nal_ch.valid = 1'b0;
        nal_ch.nal_byte = '0;
        nal_ch.nal_start = 1'b0;
        nal_ch.nal_length = '0;
        nal_ch.frame_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SSRC_ID;
        cfg_ch.data = '0;
        pkt_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        fail_count = 0;
        quiet_cycles = 0;

        reg_ssrc = SSRC_RESET;
        reg_pt = PT_RESET;
        reg_maxp = MAXP_RESET;
        seq_no = '0;
        nal_hdr = '0;
        payload_left = '0;
        chunk_bytes = '0;
        pkt_ts = '0;
        open_first = 1'b1;
        single_pkt = 1'b0;

        // Directed part. Right after reset the SSRC is zero, the payload type
        // is 96 and the sequence number starts at zero, so the first header-only
        // packets can be written out by hand.
        directed.push_back(golden_row(8'h65, 16'd1, 32'h0102_0304,
                                      104'h80_E0_0000_01020304_00000000_65));
        // A length of zero is treated like a header-only NAL.
        directed.push_back(golden_row(8'hFF, 16'd0, 32'hFFFF_FFFF,
                                      104'h80_E0_0001_FFFFFFFF_00000000_FF));
        // A stray byte with no NAL open is dropped.
        directed.push_back(nal_row(8'h00, 1'b0, 16'hFFFF, 32'h0));
        // A small NAL goes out as one single NAL unit packet.
        directed.push_back(nal_row(8'h41, 1'b1, 16'd3, 32'h0));
        directed.push_back(nal_row(8'hFF, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h00, 1'b0, 16'd0, 32'h0));
        directed.push_back(cfg_row(REG_MAX_PAYLOAD, 32'd2));
        directed.push_back(cfg_row(REG_SSRC_ID, 32'hFFFF_FFFF));
        directed.push_back(cfg_row(REG_PAYLOAD_TYPE, 32'd127));
        // Five payload bytes in chunks of two: start, middle and end fragments,
        // with the F and NRI bits of the header copied into the FU indicator.
        directed.push_back(nal_row(8'hE5, 1'b1, 16'd6, 32'h1234_5678));
        directed.push_back(nal_row(8'h80, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h7F, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'hFF, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h00, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h55, 1'b0, 16'd0, 32'h0));
        // Four payload bytes, an exact multiple: no empty packet at the end.
        directed.push_back(nal_row(8'h7C, 1'b1, 16'd5, 32'h0));
        directed.push_back(nal_row(8'h01, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h02, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h03, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'h04, 1'b0, 16'd0, 32'h0));
        // The longest NAL, abandoned by a new header one byte into its first
        // fragment. The new header-only packet carries sequence number 9, the
        // all-ones SSRC and payload type 127 with the marker set.
        directed.push_back(nal_row(8'h61, 1'b1, 16'hFFFF, 32'h0));
        directed.push_back(nal_row(8'hAA, 1'b0, 16'd0, 32'h0));
        directed.push_back(golden_row(8'h06, 16'd1, 32'h0,
                                      104'h80_FF_0009_00000000_FFFFFFFF_06));
        // A max_payload of zero is raised to one byte per fragment.
        directed.push_back(cfg_row(REG_MAX_PAYLOAD, 32'd0));
        directed.push_back(nal_row(8'h1F, 1'b1, 16'd3, 32'hFFFF_FFFF));
        directed.push_back(nal_row(8'h5A, 1'b0, 16'd0, 32'h0));
        directed.push_back(nal_row(8'hA5, 1'b0, 16'd0, 32'h0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                wait_for_packets();
                write_reg(directed[i].idx, directed[i].data);
            end
            else
            begin
                push_nal(directed[i].req.nbyte, directed[i].req.start,
                         directed[i].req.len, directed[i].req.ts);
                // The hand-written packet replaces the 13 predicted bytes of this
                // row, which sit at the back of the queue. Older bytes may have
                // drained meanwhile, but the first new byte cannot have left yet.
                if (directed[i].golden_on)
                begin
                    repeat (CNT_HEADER_ONLY)
                        void'(pending_bytes.pop_back());
                    for (k = 0; k < CNT_HEADER_ONLY; k++)
                        emit(directed[i].golden[103 - 8 * k -: 8], k == 0,
                             k == CNT_HEADER_ONLY - 1);
                end
            end
        end

        // Random part, five phases over four idle patterns, with the register extremes
        // spread over the phases.
        run_phase(0, 0, $urandom, 7'($urandom), 11'd2047);
        run_phase(83, 0, 32'hFFFF_FFFF, 7'd127, 11'd4);
        run_phase(0, 83, 32'h0, 7'd0, 11'd0);
        run_phase(28, 28, $urandom, 7'($urandom), 11'd3);
        run_phase(0, 0, $urandom, PT_RESET, 11'($urandom_range(1, 8)));

        // Drain the output, then watch a while longer for stray bytes.
        wait_for_packets();
        repeat (END_SETTLE) @(posedge clk);
        fail_count += pending_bytes.size();
        if (fail_count == 0)
            $display("h264_rtp_fua_packetizer_tb: PASS");
        else
            $display("h264_rtp_fua_packetizer_tb: FAIL");
        $finish;
    end

endmodule

@@ h264_rtp_fua_packetizer.f @@
src/h264fua_pkg.sv
src/h264fua_if.sv
src/h264fua_ctl.sv
src/h264fua_emit.sv
src/h264_rtp_fua_packetizer.sv
sim/h264_rtp_fua_packetizer_tb.sv
